/* rtl/twes_pkg.sv */
package twes_pkg;

    localparam int ENTRY_DEPTH      = 8;
    localparam int EVENTS_PER_ENTRY = 8;
    localparam int EVENT_BITS       = 8;
    localparam int SLOT_W           = $clog2(ENTRY_DEPTH);
    localparam int USED_W           = $clog2(ENTRY_DEPTH + 1);
    localparam int POS_W            = $clog2(EVENTS_PER_ENTRY);
    localparam int FILL_W           = $clog2(EVENTS_PER_ENTRY + 1);
    localparam int BYTE_ADDR_W      = $clog2(ENTRY_DEPTH * EVENTS_PER_ENTRY);
    localparam int TIME_W           = 64;
    localparam int WIN_W            = 16;
    localparam int COUNT_W          = 7;
    localparam int MODE_W           = 2;
    localparam int STATUS_W         = 2;
    localparam logic [10:0] US_PER_MS_X2 = 11'd2000;

    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EXACT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    typedef enum logic [1:0] {
        CMP_BELOW,
        CMP_EXACT,
        CMP_RANGE
    } cmp_op_t;

endpackage

/* rtl/twes_cmp.sv */
module twes_cmp (
    input  twes_pkg::cmp_op_t                op,
    input  logic [twes_pkg::TIME_W-1:0]      slot_time,
    input  logic [twes_pkg::TIME_W-1:0]      lo,
    input  logic [twes_pkg::TIME_W-1:0]      hi,
    output logic                             hit
);
    import twes_pkg::*;

    always_comb
    begin
        case (op)
            CMP_BELOW: hit = slot_time < lo;
            CMP_EXACT: hit = slot_time == lo;
            CMP_RANGE: hit = (slot_time >= lo) && (slot_time <= hi);
            default:   hit = 1'b0;
        endcase
    end

endmodule

/* rtl/time_window_event_store.sv */
// Commands are taken when start is high and busy is low. An add element
// without last, a rejected add and an item with mode three are finished on
// acceptance and busy stays low; only the rejected add gives a result, in the
// next cycle. Other items use a single shared time comparator on one stored
// entry per cycle, pausing the scan while a hit entry's bytes are returned:
// an accepted add holds busy while it computes the age limit and drops old
// entries, and a lookup holds busy while it counts the matching bytes and
// then returns them. Results appear on done for one cycle each and cannot
// be stalled; final_res marks the last result of an item.
module time_window_event_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [twes_pkg::WIN_W-1:0]          cfg_wdata,
    input  logic [twes_pkg::MODE_W-1:0]         mode,
    input  logic [twes_pkg::TIME_W-1:0]         time_req,
    input  logic [twes_pkg::TIME_W-1:0]         range_end,
    input  logic [twes_pkg::EVENT_BITS-1:0]     event_value,
    input  logic                                has_data,
    input  logic                                last,
    output logic                                done,
    output logic [twes_pkg::STATUS_W-1:0]       status,
    output logic [twes_pkg::EVENT_BITS-1:0]     event_out,
    output logic [twes_pkg::COUNT_W-1:0]        count,
    output logic                                final_res
);
    import twes_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_DROP,
        S_COUNT,
        S_EMIT_SCAN,
        S_EMIT_BYTES
    } state_t;

    logic [TIME_W-1:0]      slot_time_mem [ENTRY_DEPTH];
    logic [FILL_W-1:0]      slot_len_mem  [ENTRY_DEPTH];
    logic [EVENT_BITS-1:0]  byte_mem      [ENTRY_DEPTH*EVENTS_PER_ENTRY];

    state_t                 state_reg;
    logic [WIN_W-1:0]       window_reg;
    logic [SLOT_W-1:0]      oldest_reg;
    logic [USED_W-1:0]      used_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic                   overflow_reg;
    logic                   exact_reg;
    logic [TIME_W-1:0]      lo_reg;
    logic [TIME_W-1:0]      hi_reg;
    logic [USED_W-1:0]      idx_reg;
    logic [COUNT_W-1:0]     total_reg;
    logic [COUNT_W-1:0]     emitted_reg;
    logic [SLOT_W-1:0]      cur_slot_reg;
    logic [FILL_W-1:0]      cur_len_reg;
    logic [FILL_W-1:0]      pos_reg;
    logic [BYTE_ADDR_W-1:0] rd_addr_reg;
    logic                   rd_pend_reg;

    logic                   done_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [EVENT_BITS-1:0]  event_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   final_reg;

    logic [SLOT_W-1:0]      scan_slot;
    logic [SLOT_W-1:0]      tail_slot;
    cmp_op_t                cmp_op;
    logic                   hit;
    logic [WIN_W+11:0]      span;
    logic                   accept;
    logic                   scan_end;
    logic                   done_next;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign scan_slot = oldest_reg + idx_reg[SLOT_W-1:0];
    assign tail_slot = oldest_reg + used_reg[SLOT_W-1:0];
    assign span      = (WIN_W+12)'(window_reg) * (WIN_W+12)'(US_PER_MS_X2);
    assign scan_end  = (idx_reg >= used_reg) || (exact_reg && total_reg != '0);
    assign done_next = rd_pend_reg || (accept && mode == MODE_ADD && last)
                       || (state_reg == S_COUNT && scan_end && total_reg == '0);

    always_comb
    begin
        if (state_reg == S_DROP)
            cmp_op = CMP_BELOW;
        else if (exact_reg)
            cmp_op = CMP_EXACT;
        else
            cmp_op = CMP_RANGE;
    end

    twes_cmp u_cmp (
        .op        (cmp_op),
        .slot_time (slot_time_mem[state_reg == S_DROP ? oldest_reg : scan_slot]),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .hit       (hit)
    );

    always_ff @(posedge clk)
    begin
        if (accept && mode == MODE_ADD && has_data
            && fill_reg < FILL_W'(EVENTS_PER_ENTRY) && used_reg < USED_W'(ENTRY_DEPTH))
            byte_mem[{tail_slot, fill_reg[POS_W-1:0]}] <= event_value;
        if (accept && mode == MODE_ADD && last && !overflow_reg
            && used_reg < USED_W'(ENTRY_DEPTH))
        begin
            slot_time_mem[tail_slot] <= time_req;
            slot_len_mem[tail_slot]  <= fill_reg + FILL_W'(has_data
                && fill_reg < FILL_W'(EVENTS_PER_ENTRY));
        end
        event_reg <= rd_pend_reg ? byte_mem[rd_addr_reg] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            window_reg   <= WIN_W'(1000);
            oldest_reg   <= '0;
            used_reg     <= '0;
            fill_reg     <= '0;
            overflow_reg <= 1'b0;
            exact_reg    <= 1'b0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            idx_reg      <= '0;
            total_reg    <= '0;
            emitted_reg  <= '0;
            cur_slot_reg <= '0;
            cur_len_reg  <= '0;
            pos_reg      <= '0;
            rd_addr_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= STATUS_OK;
            count_reg    <= '0;
            final_reg    <= 1'b0;
        end
        else
        begin
            done_reg    <= done_next;
            rd_pend_reg <= (state_reg == S_EMIT_BYTES);
            if (cfg_we)
                window_reg <= cfg_wdata;
            if (rd_pend_reg)
            begin
                status_reg <= STATUS_OK;
                count_reg  <= total_reg;
                final_reg  <= (emitted_reg == total_reg);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && mode == MODE_ADD)
                    begin
                        if (last)
                        begin
                            fill_reg     <= '0;
                            overflow_reg <= 1'b0;
                            count_reg    <= '0;
                            final_reg    <= 1'b1;
                            if ((has_data && fill_reg >= FILL_W'(EVENTS_PER_ENTRY))
                                || overflow_reg || used_reg >= USED_W'(ENTRY_DEPTH))
                                status_reg <= STATUS_REJECTED;
                            else
                            begin
                                status_reg <= STATUS_OK;
                                used_reg   <= used_reg + USED_W'(1);
                                hi_reg     <= time_req;
                                state_reg  <= S_SPAN;
                            end
                        end
                        else if (has_data)
                        begin
                            if (fill_reg >= FILL_W'(EVENTS_PER_ENTRY))
                                overflow_reg <= 1'b1;
                            else
                                fill_reg <= fill_reg + FILL_W'(1);
                        end
                    end
                    else if (accept && (mode == MODE_EXACT || mode == MODE_RANGE))
                    begin
                        exact_reg   <= (mode == MODE_EXACT);
                        lo_reg      <= time_req;
                        hi_reg      <= range_end;
                        idx_reg     <= '0;
                        total_reg   <= '0;
                        state_reg   <= S_COUNT;
                    end
                end
                S_SPAN:
                begin
                    lo_reg    <= (hi_reg > TIME_W'(span)) ? hi_reg - TIME_W'(span) : '0;
                    state_reg <= S_DROP;
                end
                S_DROP:
                begin
                    if (used_reg != '0 && hit)
                    begin
                        oldest_reg <= oldest_reg + SLOT_W'(1);
                        used_reg   <= used_reg - USED_W'(1);
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_COUNT:
                begin
                    if (scan_end)
                    begin
                        idx_reg     <= '0;
                        emitted_reg <= '0;
                        if (total_reg == '0)
                        begin
                            status_reg <= STATUS_EMPTY;
                            count_reg  <= '0;
                            final_reg  <= 1'b1;
                            state_reg  <= S_IDLE;
                        end
                        else
                            state_reg <= S_EMIT_SCAN;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            total_reg <= total_reg + COUNT_W'(slot_len_mem[scan_slot]);
                            if (exact_reg && slot_len_mem[scan_slot] == '0)
                                idx_reg <= used_reg;
                            else
                                idx_reg <= idx_reg + USED_W'(1);
                        end
                        else
                            idx_reg <= idx_reg + USED_W'(1);
                    end
                end
                S_EMIT_SCAN:
                begin
                    if (emitted_reg == total_reg)
                    begin
                        if (!rd_pend_reg)
                            state_reg <= S_IDLE;
                    end
                    else if (hit && slot_len_mem[scan_slot] != '0)
                    begin
                        cur_slot_reg <= scan_slot;
                        cur_len_reg  <= slot_len_mem[scan_slot];
                        pos_reg      <= '0;
                        idx_reg      <= idx_reg + USED_W'(1);
                        state_reg    <= S_EMIT_BYTES;
                    end
                    else
                        idx_reg <= idx_reg + USED_W'(1);
                end
                S_EMIT_BYTES:
                begin
                    rd_addr_reg <= {cur_slot_reg, pos_reg[POS_W-1:0]};
                    emitted_reg <= emitted_reg + COUNT_W'(1);
                    pos_reg     <= pos_reg + FILL_W'(1);
                    if (pos_reg + FILL_W'(1) == cur_len_reg)
                        state_reg <= S_EMIT_SCAN;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign event_out = event_reg;
    assign count     = count_reg;
    assign final_res = final_reg;

endmodule

/* rtl/twes_checker.sv */
module twes_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                busy,
    input logic                                done,
    input logic [twes_pkg::STATUS_W-1:0]       status,
    input logic [twes_pkg::EVENT_BITS-1:0]     event_out,
    input logic [twes_pkg::COUNT_W-1:0]        count,
    input logic                                final_res
);
    import twes_pkg::*;

    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && count == '0 |-> final_res && event_out == '0)
        else $error("empty answer malformed");

    a_status_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != STATUS_OK |-> count == '0)
        else $error("non-ok status with bytes");

    a_partial_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        done && !final_res |-> status == STATUS_OK && count != '0)
        else $error("non-final result outside a byte stream");

    a_busy_on_stream: assert property (@(posedge clk) disable iff (!rst_n)
        done && !final_res |-> busy)
        else $error("idle during result stream");

endmodule

bind time_window_event_store twes_checker u_twes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .event_out (event_out),
    .count     (count),
    .final_res (final_res)
);
